// ===== sv/lesf_pkg.sv =====
package lesf_pkg;

	// widths of the port fields
	localparam int CHAR_W      = 8;
	localparam int DIM_W       = 11;
	localparam int POS_OUT_W   = 10;
	localparam int SIZE_OUT_W  = 11;
	localparam int CFG_IDX_W   = 2;

	// default grid limits
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd2;

	// reset values of the registers
	localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;

endpackage

// ===== sv/lesf_ram.sv =====
module lesf_ram import lesf_pkg::*; #(
	parameter int WIDTH = DIM_W,
	parameter int DEPTH = DEF_MAX_COLS,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/largest_empty_square_finder.sv =====
// Largest empty square finder.
// Cells of a grid arrive on the input channel (in_valid/in_ready, cell_char)
// in raster order, one cell per transfer. A cell is free when it matches
// empty_char. After the last cell of the grid one result leaves on the output
// channel (out_valid/out_ready): found, top_row, left_col and square_size of
// the largest free square, the topmost then leftmost one among equals.
// Registers are written over the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data): 0 empty_char, 1 row_count, 2 col_count. Dimensions saturate to
// 1..MAX_ROWS and 1..MAX_COLS. A write to a known register restarts the grid;
// writes are meant for an idle block only.
// Throughput is one cell per cycle unless the result stalls (see below). The
// line buffer entry of a cell is read from a single-port-read RAM in the cycle
// the cell is taken in, and the run, best square and result are formed from
// the input register; the result is registered when the last cell leaves it.
// If the receiver stalls, the result is held and input keeps flowing until
// the next grid's last cell, which then waits in the input register.
// Reset clears the position, the best square and the registers to their
// defaults; the line buffer is not cleared, its row-0 entries are never used.
module largest_empty_square_finder import lesf_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     cell_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [POS_OUT_W-1:0]  top_row,
	output logic [POS_OUT_W-1:0]  left_col,
	output logic [SIZE_OUT_W-1:0] square_size
);

	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RUN_MAX = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int RUN_W   = $clog2(RUN_MAX + 1);

	// configuration
	logic [CHAR_W-1:0] empty_char_q;
	logic [ROW_W-1:0]  row_last_q;
	logic [COL_W-1:0]  col_last_q;
	logic [ROW_W-1:0]  row_last_d;
	logic [COL_W-1:0]  col_last_d;
	logic              cfg_xfer;
	logic              restart;

	// input side
	logic              in_xfer;
	logic [COL_W-1:0]  col_in_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] cell_s1;
	logic              byp_q;
	logic [RUN_W-1:0]  byp_run_q;
	logic [RUN_W-1:0]  ram_rdata;

	// scan state
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [RUN_W-1:0]  left_run_q;
	logic [RUN_W-1:0]  diag_run_q;
	logic [RUN_W-1:0]  best_size_q;
	logic [ROW_W-1:0]  best_row_q;
	logic [COL_W-1:0]  best_col_q;

	// cell datapath
	logic              fire_s1;
	logic              last_col;
	logic              last_cell;
	logic [RUN_W-1:0]  above;
	logic [RUN_W-1:0]  up;
	logic [RUN_W-1:0]  left;
	logic [RUN_W-1:0]  diag;
	logic [RUN_W-1:0]  min_run;
	logic [RUN_W-1:0]  run;
	logic              better;
	logic [RUN_W-1:0]  best_size_nxt;
	logic [ROW_W-1:0]  best_row_nxt;
	logic [COL_W-1:0]  best_col_nxt;

	// output register
	logic                  out_valid_q;
	logic                  found_q;
	logic [POS_OUT_W-1:0]  top_row_q;
	logic [POS_OUT_W-1:0]  left_col_q;
	logic [SIZE_OUT_W-1:0] square_size_q;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign restart   = cfg_xfer && (cfg_index == REG_EMPTY_CHAR || cfg_index == REG_ROW_COUNT
		|| cfg_index == REG_COL_COUNT);

	// saturate dimensions and keep the last index
	always_comb begin
		if (cfg_data == '0) begin
			row_last_d = '0;
			col_last_d = '0;
		end else begin
			if (32'(cfg_data) > MAX_ROWS) begin
				row_last_d = ROW_W'(MAX_ROWS - 1);
			end else begin
				row_last_d = ROW_W'(cfg_data - 11'd1);
			end
			if (32'(cfg_data) > MAX_COLS) begin
				col_last_d = COL_W'(MAX_COLS - 1);
			end else begin
				col_last_d = COL_W'(cfg_data - 11'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= EMPTY_CHAR_RST;
			row_last_q   <= '0;
			col_last_q   <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				REG_EMPTY_CHAR: empty_char_q <= cfg_data[CHAR_W-1:0];
				REG_ROW_COUNT:  row_last_q   <= row_last_d;
				REG_COL_COUNT:  col_last_q   <= col_last_d;
				default: ;
			endcase
		end
	end

	// the last cell of a grid waits while the previous result is still held
	assign last_col  = (cur_col_q == col_last_q);
	assign last_cell = last_col && (cur_row_q == row_last_q);
	assign fire_s1   = valid_s1 && (!last_cell || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign in_xfer   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_in_q <= '0;
			byp_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (restart) begin
				col_in_q <= '0;
			end else if (in_xfer) begin
				col_in_q <= (col_in_q == col_last_q) ? '0 : col_in_q + 1'b1;
			end
			// same column written while read: forward the new run
			if (in_xfer) begin
				byp_q <= fire_s1 && (col_in_q == cur_col_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cell_s1   <= cell_char;
			byp_run_q <= run;
		end
	end

	lesf_ram #(
		.WIDTH (RUN_W),
		.DEPTH (MAX_COLS)
	) u_line_buf (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (cur_col_q),
		.wdata (run),
		.re    (in_xfer),
		.raddr (col_in_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		above   = byp_q ? byp_run_q : ram_rdata;
		up      = (cur_row_q == '0) ? '0 : above;
		left    = (cur_col_q == '0) ? '0 : left_run_q;
		diag    = (cur_row_q == '0 || cur_col_q == '0) ? '0 : diag_run_q;
		min_run = up;
		if (left < min_run) begin
			min_run = left;
		end
		if (diag < min_run) begin
			min_run = diag;
		end
		run = (cell_s1 == empty_char_q) ? min_run + 1'b1 : '0;

		better        = run > best_size_q;
		best_size_nxt = best_size_q;
		best_row_nxt  = best_row_q;
		best_col_nxt  = best_col_q;
		if (better) begin
			best_size_nxt = run;
			best_row_nxt  = ROW_W'({1'b0, cur_row_q} + 1'b1 - (ROW_W + 1)'(run));
			best_col_nxt  = COL_W'({1'b0, cur_col_q} + 1'b1 - (COL_W + 1)'(run));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			left_run_q  <= '0;
			diag_run_q  <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (restart) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			left_run_q  <= '0;
			diag_run_q  <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (fire_s1) begin
			if (last_col) begin
				cur_col_q  <= '0;
				left_run_q <= '0;
				diag_run_q <= '0;
			end else begin
				cur_col_q  <= cur_col_q + 1'b1;
				left_run_q <= run;
				diag_run_q <= up;
			end
			if (last_cell) begin
				cur_row_q   <= '0;
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				if (last_col) begin
					cur_row_q <= cur_row_q + 1'b1;
				end
				best_size_q <= best_size_nxt;
				best_row_q  <= best_row_nxt;
				best_col_q  <= best_col_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_cell) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_cell) begin
			found_q       <= (best_size_nxt != '0);
			top_row_q     <= POS_OUT_W'(best_row_nxt);
			left_col_q    <= POS_OUT_W'(best_col_nxt);
			square_size_q <= SIZE_OUT_W'(best_size_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign top_row     = top_row_q;
	assign left_col    = left_col_q;
	assign square_size = square_size_q;

endmodule
